FILE: hw/rtl/bmls_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the byte memory load/store unit.
package bmls_pkg;

  // Geometry
  localparam int ADDR_W     = 12;
  localparam int DATA_W     = 32;
  localparam int SIZE_W     = 3;
  localparam int MEM_BYTES  = 4096;
  localparam int LANES      = 4;
  localparam int WORD_DEPTH = MEM_BYTES / LANES;
  localparam int WORD_AW    = $clog2(WORD_DEPTH);
  localparam int SPAN_W     = ADDR_W + 1;
  localparam int LEN_W      = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ADDR_W-1:0] TEXT_LIMIT_RESET = 12'h7FF;

  // Load size codes
  localparam logic [SIZE_W-1:0] LD_SB = 3'b000;
  localparam logic [SIZE_W-1:0] LD_SH = 3'b001;
  localparam logic [SIZE_W-1:0] LD_W  = 3'b010;
  localparam logic [SIZE_W-1:0] LD_UB = 3'b011;
  localparam logic [SIZE_W-1:0] LD_UH = 3'b100;

  // Store size codes
  localparam logic [SIZE_W-1:0] SZ_B = 3'b000;
  localparam logic [SIZE_W-1:0] SZ_H = 3'b001;
  localparam logic [SIZE_W-1:0] SZ_W = 3'b010;

  typedef enum logic [1:0] {
    FUNC_FETCH   = 2'd0,
    FUNC_LOAD    = 2'd1,
    FUNC_STORE   = 2'd2,
    FUNC_PRELOAD = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNALIGNED  = 3'd1,
    ST_FETCH_OUT  = 3'd2,
    ST_STORE_TEXT = 3'd3,
    ST_BAD_SIZE   = 3'd4,
    ST_BEYOND     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_READ  = 2'd2,
    BK_RESP  = 2'd3
  } back_state_t;

  // Classified request handed from front to back
  typedef struct packed {
    status_t            status;
    op_t                op;
    logic [WORD_AW-1:0] word_idx;
    logic [1:0]         byte_off;
    logic [SIZE_W-1:0]  ld_size;
    logic [LANES-1:0]   lane_en;
    logic [DATA_W-1:0]  wdata;
  } cmd_t;

endpackage

FILE: hw/rtl/bmls_req_if.sv
`timescale 1ns / 1ps
// Request channel: access kind, size code, address and write data.
interface bmls_req_if;
  import bmls_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [SIZE_W-1:0] size_code;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, func, size_code, address, write_data, input ready);
  modport sink   (input valid, func, size_code, address, write_data, output ready);
endinterface

FILE: hw/rtl/bmls_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: read data and status.
interface bmls_rsp_if;
  import bmls_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [2:0]        status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

FILE: hw/rtl/bmls_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module bmls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/bmls_front.sv
`timescale 1ns / 1ps
// Front end: text limit register, request accept and fault classification.
module bmls_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [bmls_pkg::ADDR_W-1:0] cfg_write_data,
  bmls_req_if.sink                    req,
  input  logic                        clearing,
  input  logic                        q_full,
  output logic                        q_push,
  output bmls_pkg::cmd_t              q_cmd
);
  import bmls_pkg::*;

  logic [ADDR_W-1:0] text_limit;
  logic [LEN_W-1:0]  len;
  logic [LANES-1:0]  mask;
  logic              misaligned;
  logic              beyond;
  logic              preload_full;
  logic [SPAN_W-1:0] span_end;
  logic [1:0]        off;

  // Text limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_limit <= TEXT_LIMIT_RESET;
    end else if (cfg_write_en) begin
      text_limit <= cfg_write_data;
    end
  end

  // Accept while the queue has room and the memory is not being cleared
  assign req.ready = !q_full && !clearing;
  assign q_push    = req.valid && req.ready;
  assign off       = req.address[1:0];

  // Access length per kind and size
  always_comb begin
    len = LEN_W'(4);
    case (func_t'(req.func))
      FUNC_LOAD: begin
        if (req.size_code == LD_SB || req.size_code == LD_UB) begin
          len = LEN_W'(1);
        end else if (req.size_code == LD_W) begin
          len = LEN_W'(4);
        end else begin
          len = LEN_W'(2);
        end
      end
      FUNC_STORE: begin
        if (req.size_code == SZ_B) begin
          len = LEN_W'(1);
        end else if (req.size_code == SZ_H) begin
          len = LEN_W'(2);
        end else begin
          len = LEN_W'(4);
        end
      end
      default: len = LEN_W'(4);
    endcase
  end

  assign mask = (len == LEN_W'(1)) ? 4'b0001 :
                (len == LEN_W'(2)) ? 4'b0011 : 4'b1111;
  assign misaligned   = (off & (len[1:0] - 2'd1)) != 2'd0;
  assign span_end     = {1'b0, req.address} + SPAN_W'(len);
  assign beyond       = span_end > SPAN_W'(MEM_BYTES);
  assign preload_full = ({1'b0, req.address} + SPAN_W'(3)) >= {1'b0, text_limit};

  // Fault priority per access kind
  always_comb begin
    q_cmd.status   = ST_OK;
    q_cmd.op       = OP_NONE;
    q_cmd.word_idx = req.address[WORD_AW+1:2];
    q_cmd.byte_off = off;
    q_cmd.ld_size  = LD_W;
    q_cmd.lane_en  = LANES'(mask << off);
    q_cmd.wdata    = req.write_data << {off, 3'b000};
    case (func_t'(req.func))
      FUNC_FETCH: begin
        if (req.address > text_limit) begin
          q_cmd.status = ST_FETCH_OUT;
        end else if (misaligned) begin
          q_cmd.status = ST_UNALIGNED;
        end else if (beyond) begin
          q_cmd.status = ST_BEYOND;
        end else begin
          q_cmd.op = OP_READ;
        end
      end
      FUNC_LOAD: begin
        q_cmd.ld_size = req.size_code;
        if (req.size_code > LD_UH) begin
          q_cmd.status = ST_BAD_SIZE;
        end else if (misaligned) begin
          q_cmd.status = ST_UNALIGNED;
        end else if (beyond) begin
          q_cmd.status = ST_BEYOND;
        end else begin
          q_cmd.op = OP_READ;
        end
      end
      FUNC_STORE: begin
        if (req.address <= text_limit) begin
          q_cmd.status = ST_STORE_TEXT;
        end else if (req.size_code > SZ_W) begin
          q_cmd.status = ST_BAD_SIZE;
        end else if (misaligned) begin
          q_cmd.status = ST_UNALIGNED;
        end else if (beyond) begin
          q_cmd.status = ST_BEYOND;
        end else begin
          q_cmd.op = OP_WRITE;
        end
      end
      FUNC_PRELOAD: begin
        if (misaligned) begin
          q_cmd.status = ST_UNALIGNED;
        end else if (preload_full || beyond) begin
          q_cmd.status = ST_BEYOND;
        end else begin
          q_cmd.op = OP_WRITE;
        end
      end
      default: q_cmd.status = ST_OK;
    endcase
  end

endmodule

FILE: hw/rtl/bmls_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified requests between front and back.
module bmls_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bmls_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output bmls_pkg::cmd_t head
);
  import bmls_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

FILE: hw/rtl/bmls_back.sv
`timescale 1ns / 1ps
// Back end: memory clear, memory access, result formatting and response register.
module bmls_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  bmls_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           clearing,
  bmls_rsp_if.source     rsp
);
  import bmls_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic [WORD_AW-1:0] clr_idx;
  logic [WORD_AW-1:0] clr_idx_next;
  cmd_t               cur;
  cmd_t               cur_next;
  logic [DATA_W-1:0]  out_data;
  logic [DATA_W-1:0]  out_data_next;
  status_t            out_status;
  status_t            out_status_next;

  logic [WORD_AW-1:0] ram_addr;
  logic [LANES-1:0]   ram_we;
  logic [DATA_W-1:0]  ram_wdata;
  logic [DATA_W-1:0]  ram_rdata;
  logic [DATA_W-1:0]  shifted;
  logic [DATA_W-1:0]  formatted;

  // One byte lane per RAM
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bmls_ram #(
      .WIDTH(8),
      .DEPTH(WORD_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[i]),
      .addr (ram_addr),
      .wdata(ram_wdata[8*i +: 8]),
      .rdata(ram_rdata[8*i +: 8])
    );
  end

  // Extract and extend the loaded value
  assign shifted = ram_rdata >> {cur.byte_off, 3'b000};
  always_comb begin
    formatted = '0;
    if (cur.op == OP_READ) begin
      case (cur.ld_size)
        LD_SB:   formatted = {{24{shifted[7]}}, shifted[7:0]};
        LD_SH:   formatted = {{16{shifted[15]}}, shifted[15:0]};
        LD_W:    formatted = ram_rdata;
        LD_UB:   formatted = {24'd0, shifted[7:0]};
        LD_UH:   formatted = {16'd0, shifted[15:0]};
        default: formatted = '0;
      endcase
    end
  end

  // State and payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    out_data   <= out_data_next;
    out_status <= out_status_next;
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    clr_idx_next    = clr_idx;
    cur_next        = cur;
    out_data_next   = out_data;
    out_status_next = out_status;
    q_pop           = 1'b0;
    ram_addr        = q_head.word_idx;
    ram_we          = '0;
    ram_wdata       = q_head.wdata;
    rsp.valid       = 1'b0;
    case (state)
      BK_CLEAR: begin
        ram_addr     = clr_idx;
        ram_we       = '1;
        ram_wdata    = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == WORD_AW'(WORD_DEPTH - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_next   = q_head;
          state_next = BK_READ;
          if (q_head.op == OP_WRITE) begin
            ram_we = q_head.lane_en;
          end
        end
      end
      BK_READ: begin
        out_data_next   = formatted;
        out_status_next = cur.status;
        state_next      = BK_RESP;
      end
      BK_RESP: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign clearing      = state == BK_CLEAR;
  assign rsp.read_data = out_data;
  assign rsp.status    = out_status;

endmodule

FILE: hw/rtl/byte_memory_load_store_unit.sv
`timescale 1ns / 1ps
// Top level of the byte memory load/store unit.
// A 4 KiB little-endian byte memory, built as four byte-lane RAMs of 1024 words, serving
// fetch, load, store and image-preload requests with one response per request. The front
// end checks each request against the text limit, alignment, size code and memory bounds
// and queues it (two entries); the back end performs the access and returns read data and
// status. The back end handles one request at a time: it accesses the RAMs, formats the
// registered read data into the response register, and holds the response until taken;
// the front end keeps accepting requests meanwhile, until the queue fills.
// After reset a clearing pass writes zeros to all 1024 words, one word per cycle, and no
// request is accepted during it; text_limit writes are taken at any time and reset to 0x7FF.
module byte_memory_load_store_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [bmls_pkg::ADDR_W-1:0] cfg_write_data,
  bmls_req_if.sink                    req,
  bmls_rsp_if.source                  rsp
);
  import bmls_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  logic clearing;

  bmls_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .req           (req),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  bmls_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (head_cmd)
  );

  bmls_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (head_cmd),
    .q_pop   (q_pop),
    .clearing(clearing),
    .rsp     (rsp)
  );

endmodule

FILE: tb/sv/byte_memory_load_store_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the byte memory load/store unit, checked against a local memory model.
module byte_memory_load_store_unit_tb;
  import bmls_pkg::*;

  // Size codes that fall outside the load and store tables
  localparam logic [SIZE_W-1:0] SIZE_LD_BAD = LD_UH + 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_ST_BAD = SZ_W + 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_TOP    = 3'd7;
  localparam logic [ADDR_W-1:0] ADDR_TOP    = 12'hFFF;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    status_t           status;
  } mem_result_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [ADDR_W-1:0] cfg_write_data;

  bmls_req_if req_ch ();
  bmls_rsp_if rsp_ch ();

  byte_memory_load_store_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req_ch),
    .rsp            (rsp_ch)
  );

  // Local copy of the memory and the text limit
  logic [7:0]        model_mem [MEM_BYTES];
  logic [ADDR_W-1:0] model_text_limit;
  mem_result_t       expected_rsp_q [$];

  int unsigned error_count;
  int unsigned req_count;
  int unsigned rsp_count;
  int unsigned limit_writes;
  int unsigned status_count [6];
  bit          steady_flow;
  int          hot_base;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [DATA_W-1:0] read_bytes(int unsigned ad, int unsigned len);
    logic [DATA_W-1:0] v;
    v = '0;
    for (int unsigned i = 0; i < len; i++) v[8*i +: 8] = model_mem[ad + i];
    return v;
  endfunction

  function automatic void write_bytes(int unsigned ad, int unsigned len, logic [DATA_W-1:0] v);
    for (int unsigned i = 0; i < len; i++) model_mem[ad + i] = v[8*i +: 8];
  endfunction

  function automatic int unsigned load_len(logic [SIZE_W-1:0] sz);
    if (sz == LD_SB || sz == LD_UB) return 1;
    if (sz == LD_W) return 4;
    return 2;
  endfunction

  // Expected response of one access; updates the local memory on success
  function automatic mem_result_t model_access(func_t f, logic [SIZE_W-1:0] sz,
                                               logic [ADDR_W-1:0] a, logic [DATA_W-1:0] wd);
    mem_result_t r;
    int unsigned ad;
    int unsigned len;
    logic [DATA_W-1:0] v;
    r.read_data = '0;
    r.status = ST_OK;
    ad = 32'(a);
    case (f)
      FUNC_FETCH: begin
        if (a > model_text_limit) r.status = ST_FETCH_OUT;
        else if (a[1:0] != 2'b00) r.status = ST_UNALIGNED;
        else if (ad + 4 > MEM_BYTES) r.status = ST_BEYOND;
        else r.read_data = read_bytes(ad, 4);
      end
      FUNC_LOAD: begin
        if (sz > LD_UH) r.status = ST_BAD_SIZE;
        else begin
          len = load_len(sz);
          if ((ad & (len - 1)) != 0) r.status = ST_UNALIGNED;
          else if (ad + len > MEM_BYTES) r.status = ST_BEYOND;
          else begin
            v = read_bytes(ad, len);
            if (sz == LD_SB) v = {{24{v[7]}}, v[7:0]};
            if (sz == LD_SH) v = {{16{v[15]}}, v[15:0]};
            r.read_data = v;
          end
        end
      end
      FUNC_STORE: begin
        if (a <= model_text_limit) r.status = ST_STORE_TEXT;
        else if (sz > SZ_W) r.status = ST_BAD_SIZE;
        else begin
          len = 1 << sz;
          if ((ad & (len - 1)) != 0) r.status = ST_UNALIGNED;
          else if (ad + len > MEM_BYTES) r.status = ST_BEYOND;
          else write_bytes(ad, len, wd);
        end
      end
      default: begin
        // image preload: the whole word must sit below the text limit
        if (a[1:0] != 2'b00) r.status = ST_UNALIGNED;
        else if (ad + 3 >= model_text_limit) r.status = ST_BEYOND;
        else if (ad + 4 > MEM_BYTES) r.status = ST_BEYOND;
        else write_bytes(ad, 4, wd);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("MISMATCH response %0d %s: got %h, want %h", rsp_count, what, got, want);
    error_count++;
  endtask

  // Sends one request; returns at the edge that accepted it
  task automatic send_req(func_t f, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a,
                          logic [DATA_W-1:0] wd);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.size_code  <= sz;
    req_ch.address    <= a;
    req_ch.write_data <= wd;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_rsp_q.push_back(model_access(f, sz, a, wd));
    req_count++;
  endtask

  // Hold requests until every response is back
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_text_limit(logic [ADDR_W-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    model_text_limit = value;
    limit_writes++;
  endtask

  // Aligned start address whose access lies in [lo, last]; random if none fits
  function automatic logic [ADDR_W-1:0] pick_aligned(int lo, int last, int len);
    int hi;
    int a;
    if (last > MEM_BYTES - 1) last = MEM_BYTES - 1;
    if (lo < 0) lo = 0;
    hi = last - len + 1;
    a = -1;
    if (hi >= lo) begin
      a = $urandom_range(lo, hi) & ~(len - 1);
      if (a < lo) a += len;
    end
    if (a < lo || a > hi) a = $urandom_range(0, MEM_BYTES - 1) & ~(len - 1);
    return a[ADDR_W-1:0];
  endfunction

  task automatic choose_hot_window();
    hot_base = (int'(model_text_limit) + 1 + $urandom_range(0, 255)) & ~3;
    if (hot_base + 64 > MEM_BYTES) hot_base = MEM_BYTES - 64;
  endtask

  // Mostly legal accesses around a hot data window, plus some noise
  task automatic send_random_access();
    int unsigned pick;
    int lim;
    int len;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(0, 99);
    lim = int'(model_text_limit);
    sz = SIZE_W'($urandom_range(0, 7));
    if (pick < 12) begin
      send_req(func_t'($urandom_range(0, 3)), sz, ADDR_W'($urandom), $urandom);
    end else if (pick < 25) begin
      send_req(FUNC_FETCH, sz, pick_aligned(0, lim + 3, 4), $urandom);
    end else if (pick < 37) begin
      send_req(FUNC_PRELOAD, sz, pick_aligned(0, lim - 1, 4), $urandom);
    end else if (pick < 68) begin
      sz = SIZE_W'($urandom_range(SZ_B, SZ_W));
      len = 1 << sz;
      if ($urandom_range(0, 1) == 1) a = pick_aligned(hot_base > lim ? hot_base : lim + 1,
                                                      hot_base + 63, len);
      else a = pick_aligned(lim + 1, MEM_BYTES - 1, len);
      send_req(FUNC_STORE, sz, a, $urandom);
    end else begin
      sz = SIZE_W'($urandom_range(LD_SB, LD_UH));
      len = load_len(sz);
      if (pick < 88) a = pick_aligned(hot_base, hot_base + 63, len);
      else if (pick < 94) a = pick_aligned(0, lim, len);
      else a = pick_aligned(0, MEM_BYTES - 1, len);
      send_req(FUNC_LOAD, sz, a, $urandom);
    end
  endtask

  // Response side: random stalls, each response checked against the oldest expectation
  initial begin
    mem_result_t want;
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      rsp_count++;
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected response, read_data", rsp_ch.read_data, '0);
      end else begin
        want = expected_rsp_q.pop_front();
        status_count[want.status]++;
        if (rsp_ch.read_data !== want.read_data)
          report_mismatch("read_data", rsp_ch.read_data, want.read_data);
        if (rsp_ch.status !== want.status)
          report_mismatch("status", {29'd0, rsp_ch.status}, {29'd0, want.status});
      end
    end
  end

  // Edge cases at the reset text limit
  task automatic test_directed_cases();
    send_req(FUNC_FETCH, LD_SB, 12'd0, '0);
    send_req(FUNC_PRELOAD, SZ_B, 12'd0, 32'hFFFF_FFFF);
    send_req(FUNC_FETCH, SIZE_TOP, 12'd0, '0);
    send_req(FUNC_PRELOAD, SIZE_TOP, 12'd2040, 32'h8070_6050);
    send_req(FUNC_PRELOAD, SZ_W, 12'd2044, 32'h1111_2222);
    send_req(FUNC_PRELOAD, SZ_W, 12'd2, 32'h3333_4444);
    send_req(FUNC_FETCH, LD_W, 12'd2047, '0);
    send_req(FUNC_FETCH, LD_W, 12'd2048, '0);
    send_req(FUNC_FETCH, LD_W, 12'd2040, '0);
    send_req(FUNC_STORE, SZ_B, 12'd2047, 32'h0000_00AA);
    send_req(FUNC_STORE, SZ_B, 12'd2048, 32'h1234_5680);
    send_req(FUNC_LOAD, LD_SB, 12'd2048, '0);
    send_req(FUNC_LOAD, LD_UB, 12'd2048, '0);
    send_req(FUNC_STORE, SZ_H, 12'd2050, 32'hABCD_8001);
    send_req(FUNC_LOAD, LD_SH, 12'd2050, '0);
    send_req(FUNC_LOAD, LD_UH, 12'd2050, '0);
    send_req(FUNC_LOAD, LD_W, 12'd2048, '0);
    send_req(FUNC_STORE, SZ_W, 12'd4092, 32'hFFFF_FFFF);
    send_req(FUNC_LOAD, LD_W, 12'd4092, '0);
    send_req(FUNC_STORE, SIZE_ST_BAD, 12'd2048, 32'h5555_5555);
    send_req(FUNC_LOAD, SIZE_LD_BAD, 12'd2048, '0);
    send_req(FUNC_LOAD, SIZE_TOP, ADDR_TOP, '0);
    send_req(FUNC_LOAD, LD_SH, 12'd2049, '0);
    send_req(FUNC_LOAD, LD_W, 12'd2050, '0);
    send_req(FUNC_STORE, SZ_H, 12'd2049, 32'h0000_FFFF);
    send_req(FUNC_STORE, SZ_W, 12'd2050, 32'h0F0F_0F0F);
  endtask

  // Text limit at both extremes and at random values, with boundary probes
  task automatic test_text_limit_settings();
    logic [ADDR_W-1:0] limits [5];
    limits[0] = '0;
    limits[1] = ADDR_TOP;
    limits[2] = ADDR_W'($urandom);
    limits[3] = ADDR_W'($urandom_range(4, 64));
    limits[4] = TEXT_LIMIT_RESET;
    foreach (limits[k]) begin
      drain_responses();
      write_text_limit(limits[k]);
      choose_hot_window();
      steady_flow = (k == 2);
      send_req(FUNC_FETCH, LD_W, model_text_limit & ~12'd3, '0);
      send_req(FUNC_FETCH, LD_W, model_text_limit + 12'd1, '0);
      send_req(FUNC_STORE, SZ_B, model_text_limit, $urandom);
      send_req(FUNC_STORE, SZ_B, model_text_limit + 12'd1, $urandom);
      send_req(FUNC_PRELOAD, SZ_W, (model_text_limit - 12'd3) & ~12'd3, $urandom);
      send_req(FUNC_PRELOAD, SZ_W, ADDR_TOP & ~12'd3, $urandom);
      repeat (120) send_random_access();
    end
    steady_flow = 1'b0;
  endtask

  // Long random traffic with changing hot windows and flow patterns
  task automatic test_random_traffic(int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 200 == 0) begin
        choose_hot_window();
        steady_flow = ($urandom_range(0, 3) == 0);
      end
      if (i == n_items / 2) begin
        drain_responses();
        write_text_limit(ADDR_W'($urandom_range(256, 3072)));
        choose_hot_window();
      end
      send_random_access();
    end
    steady_flow = 1'b0;
  endtask

  // Main sequence
  initial begin
    rst               <= 1'b1;
    cfg_write_en      <= 1'b0;
    cfg_write_data    <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_FETCH;
    req_ch.size_code  <= '0;
    req_ch.address    <= '0;
    req_ch.write_data <= '0;
    foreach (model_mem[i]) model_mem[i] = 8'h00;
    model_text_limit = TEXT_LIMIT_RESET;
    steady_flow = 1'b0;
    hot_base = 2048;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_text_limit_settings();
    test_random_traffic(1300);

    drain_responses();
    repeat (10) @(posedge clk);
    $display("Run covered %0d requests and %0d responses over %0d text limit writes.",
             req_count, rsp_count, limit_writes);
    $display("Status mix: ok %0d, unaligned %0d, fetch out %0d, store text %0d,",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    $display("  bad size %0d, beyond %0d", status_count[4], status_count[5]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
